FILE: hdl/control_loss_and_enable_debouncer_top_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the control-loss and enable debouncer
// Shared concurrent assertion forms, clocked on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef CONTROL_LOSS_AND_ENABLE_DEBOUNCER_TOP_MACROS_SVH
`define CONTROL_LOSS_AND_ENABLE_DEBOUNCER_TOP_MACROS_SVH

// antecedent implies consequent in the same cycle
`define CLED_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("cled assertion failed: same-cycle implication");

// antecedent implies consequent in the next cycle
`define CLED_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("cled assertion failed: next-cycle implication");

`endif

FILE: hdl/cled_pkg.sv
// ----------------------------------------------------------------------------
// cled_pkg
// Shared codes, widths and types for the control-loss / enable debouncer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package cled_pkg;

  localparam int NUM_EN = 3;

  localparam int TIME_W   = 32;
  localparam int PERIOD_W = 16;
  localparam int COUNT_W  = 8;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // link status codes
  localparam logic [1:0] LINK_VALID   = 2'd0;
  localparam logic [1:0] LINK_SUSPECT = 2'd1;
  localparam logic [1:0] LINK_LOST    = 2'd2;
  localparam logic [1:0] LINK_RESTORE = 2'd3;

  // item function codes
  localparam logic FUNC_INIT = 1'b0;
  localparam logic FUNC_TICK = 1'b1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_LOSS_PERIOD  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LOSS_CONFIRM = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_EN_PERIOD    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_EN_CONFIRM   = 3'd3;

  // register reset values
  localparam logic [PERIOD_W-1:0] RST_LOSS_PERIOD  = 16'd10;
  localparam logic [COUNT_W-1:0]  RST_LOSS_CONFIRM = 8'd5;
  localparam logic [PERIOD_W-1:0] RST_EN_PERIOD    = 16'd10;
  localparam logic [COUNT_W-1:0]  RST_EN_CONFIRM   = 8'd3;

  // control from the top level to one enable debouncer
  typedef struct packed {
    logic upd;     // an item is being committed this cycle
    logic init;    // that item is an init
    logic sample;  // that item is an enable sample
    logic act;     // enable level, 1 active
  } enable_ctl_t;

endpackage

FILE: hdl/control_loss_and_enable_debouncer_top.sv
// ----------------------------------------------------------------------------
// control_loss_and_enable_debouncer_top
// An input item is held in stage 1, then committed into the result register.
// Throughput: one item per cycle while out_ready is high, single pass between input and result regs.
// Reset: synchronous, active low; state, config and valid flags take their defaults.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "control_loss_and_enable_debouncer_top_macros.svh"

module control_loss_and_enable_debouncer_top (
  input  logic                            clk,
  input  logic                            rst_n,
  // configuration write port
  input  logic                            cfg_we,
  input  logic [cled_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [cled_pkg::CFG_DATA_W-1:0] cfg_wdata,
  // input items
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            in_func,
  input  logic [cled_pkg::TIME_W-1:0]     in_now_ms,
  input  logic                            in_loss_line,
  input  logic                            in_enable_one_raw,
  input  logic                            in_enable_two_raw,
  input  logic                            in_enable_three_raw,
  // result items
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [1:0]                      out_link_state,
  output logic                            out_enable_one_active,
  output logic                            out_enable_two_active,
  output logic                            out_enable_three_active,
  output logic                            out_initial_ready
);

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [cled_pkg::PERIOD_W-1:0] loss_period_r;
  logic [cled_pkg::COUNT_W-1:0]  loss_confirm_r;
  logic [cled_pkg::PERIOD_W-1:0] en_period_r;
  logic [cled_pkg::COUNT_W-1:0]  en_confirm_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      loss_period_r  <= cled_pkg::RST_LOSS_PERIOD;
      loss_confirm_r <= cled_pkg::RST_LOSS_CONFIRM;
      en_period_r    <= cled_pkg::RST_EN_PERIOD;
      en_confirm_r   <= cled_pkg::RST_EN_CONFIRM;
    end else if (cfg_we) begin
      case (cfg_index)
        cled_pkg::CFG_LOSS_PERIOD:  loss_period_r  <= cfg_wdata;
        cled_pkg::CFG_LOSS_CONFIRM: loss_confirm_r <= cfg_wdata[cled_pkg::COUNT_W-1:0];
        cled_pkg::CFG_EN_PERIOD:    en_period_r    <= cfg_wdata;
        cled_pkg::CFG_EN_CONFIRM:   en_confirm_r   <= cfg_wdata[cled_pkg::COUNT_W-1:0];
        default: begin
          // unknown index: write dropped
        end
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Handshake. Stage 1 holds the accepted item; it commits into the state and
  // the result register whenever the result register is free or being drained.
  // --------------------------------------------------------------------------
  logic                          s1_valid_r;
  logic                          s1_func_r;
  logic [cled_pkg::TIME_W-1:0]   s1_now_r;
  logic                          s1_loss_r;
  logic [cled_pkg::NUM_EN-1:0]   s1_act_r;
  logic                          out_valid_r;
  logic                          advance;
  logic                          in_take;

  assign advance  = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || advance;
  assign in_take  = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_take) begin
        s1_valid_r <= 1'b1;
      end else if (advance) begin
        s1_valid_r <= 1'b0;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload of stage 1; enables are inverted here so 1 means active
  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_func_r <= in_func;
      s1_now_r  <= in_now_ms;
      s1_loss_r <= in_loss_line;
      s1_act_r  <= ~{in_enable_three_raw, in_enable_two_raw, in_enable_one_raw};
    end
  end

  // --------------------------------------------------------------------------
  // Loss monitor state
  // --------------------------------------------------------------------------
  logic [1:0]                    link_r;
  logic [1:0]                    link_nxt;
  logic                          loss_cand_r;
  logic                          loss_cand_nxt;
  logic [cled_pkg::COUNT_W-1:0]  loss_cnt_r;
  logic [cled_pkg::COUNT_W-1:0]  loss_cnt_nxt;
  logic [cled_pkg::TIME_W-1:0]   loss_last_r;
  logic [cled_pkg::TIME_W-1:0]   loss_last_nxt;
  logic [cled_pkg::TIME_W-1:0]   en_last_r;
  logic [cled_pkg::TIME_W-1:0]   en_last_nxt;
  logic                          ready_r;
  logic                          ready_nxt;

  // values after the immediate suspect check of a tick
  logic [1:0]                    link_pre;
  logic                          cand_pre;
  logic [cled_pkg::COUNT_W-1:0]  cnt_pre;
  logic [cled_pkg::TIME_W-1:0]   last_pre;
  logic [cled_pkg::TIME_W-1:0]   loss_elapsed;
  logic [cled_pkg::TIME_W-1:0]   en_elapsed;
  logic                          is_tick;
  logic                          loss_sample;
  logic                          en_sample;
  logic [cled_pkg::NUM_EN-1:0]   en_reached;
  logic [cled_pkg::NUM_EN-1:0]   en_stable_nxt;

  assign is_tick = (s1_func_r == cled_pkg::FUNC_TICK);

  always_comb begin
    // a loss seen while valid marks suspect at once and counts as a sample
    if (s1_loss_r && link_r == cled_pkg::LINK_VALID) begin
      link_pre = cled_pkg::LINK_SUSPECT;
      cand_pre = 1'b1;
      cnt_pre  = {{(cled_pkg::COUNT_W-1){1'b0}}, 1'b1};
      last_pre = s1_now_r;
    end else begin
      link_pre = link_r;
      cand_pre = loss_cand_r;
      cnt_pre  = loss_cnt_r;
      last_pre = loss_last_r;
    end
  end

  // wrapping differences; a backward jump reads as a long gap
  assign loss_elapsed = s1_now_r - last_pre;
  assign loss_sample  = loss_elapsed >= {{(cled_pkg::TIME_W-cled_pkg::PERIOD_W){1'b0}},
                                         loss_period_r};
  assign en_elapsed   = s1_now_r - en_last_r;

  always_comb begin
    link_nxt      = link_r;
    loss_cand_nxt = loss_cand_r;
    loss_cnt_nxt  = loss_cnt_r;
    loss_last_nxt = loss_last_r;
    en_last_nxt   = en_last_r;
    ready_nxt     = ready_r;
    en_sample     = 1'b0;
    if (!is_tick) begin
      link_nxt      = s1_loss_r ? cled_pkg::LINK_SUSPECT : cled_pkg::LINK_VALID;
      loss_cand_nxt = s1_loss_r;
      loss_cnt_nxt  = '0;
      loss_last_nxt = '0;
      en_last_nxt   = '0;
      ready_nxt     = 1'b0;
    end else begin
      link_nxt      = link_pre;
      loss_cand_nxt = cand_pre;
      loss_cnt_nxt  = cnt_pre;
      loss_last_nxt = last_pre;
      if (loss_sample) begin
        loss_last_nxt = s1_now_r;
        if (s1_loss_r != cand_pre) begin
          loss_cand_nxt = s1_loss_r;
          loss_cnt_nxt  = {{(cled_pkg::COUNT_W-1){1'b0}}, 1'b1};
        end else if (cnt_pre < loss_confirm_r) begin
          loss_cnt_nxt = cnt_pre + 1'b1;
        end
        if (loss_cnt_nxt >= loss_confirm_r) begin
          link_nxt = loss_cand_nxt ? cled_pkg::LINK_LOST : cled_pkg::LINK_VALID;
        end else if (link_pre == cled_pkg::LINK_LOST) begin
          link_nxt = cled_pkg::LINK_RESTORE;
        end
      end
      // enables are only looked at while the link is valid
      en_sample = (link_nxt == cled_pkg::LINK_VALID) &&
                  (en_elapsed >= {{(cled_pkg::TIME_W-cled_pkg::PERIOD_W){1'b0}},
                                  en_period_r});
      if (en_sample) begin
        en_last_nxt = s1_now_r;
        if (&en_reached) begin
          ready_nxt = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      link_r      <= cled_pkg::LINK_VALID;
      loss_cand_r <= 1'b0;
      loss_cnt_r  <= '0;
      loss_last_r <= '0;
      en_last_r   <= '0;
      ready_r     <= 1'b0;
    end else if (advance) begin
      link_r      <= link_nxt;
      loss_cand_r <= loss_cand_nxt;
      loss_cnt_r  <= loss_cnt_nxt;
      loss_last_r <= loss_last_nxt;
      en_last_r   <= en_last_nxt;
      ready_r     <= ready_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Enable debouncers, one per line
  // --------------------------------------------------------------------------
  for (genvar k = 0; k < cled_pkg::NUM_EN; k++) begin : g_en
    cled_pkg::enable_ctl_t en_ctl;

    assign en_ctl.upd    = advance;
    assign en_ctl.init   = !is_tick;
    assign en_ctl.sample = en_sample;
    assign en_ctl.act    = s1_act_r[k];

    cled_enable_deb u_deb (
      .clk         (clk),
      .rst_n       (rst_n),
      .ctl         (en_ctl),
      .confirm_cnt (en_confirm_r),
      .stable_nxt  (en_stable_nxt[k]),
      .reached_nxt (en_reached[k])
    );
  end

  // --------------------------------------------------------------------------
  // Result register: snapshot after the item
  // --------------------------------------------------------------------------
  logic [1:0]                  res_link_r;
  logic [cled_pkg::NUM_EN-1:0] res_en_r;
  logic                        res_ready_r;

  always_ff @(posedge clk) begin
    if (advance) begin
      res_link_r  <= link_nxt;
      res_en_r    <= en_stable_nxt;
      res_ready_r <= ready_nxt;
    end
  end

  assign out_valid               = out_valid_r;
  assign out_link_state          = res_link_r;
  assign out_enable_one_active   = res_en_r[0];
  assign out_enable_two_active   = res_en_r[1];
  assign out_enable_three_active = res_en_r[2];
  assign out_initial_ready       = res_ready_r;

  // --------------------------------------------------------------------------
  // Checks
  // --------------------------------------------------------------------------
  // ready is only ever raised by an enable sample, which needs a valid link
  `CLED_ASSERT_SAME(a_ready_rise_valid, $rose(ready_r), link_r == cled_pkg::LINK_VALID)
  // lost is only reached, and kept, with a lost candidate
  `CLED_ASSERT_SAME(a_lost_has_cand, link_r == cled_pkg::LINK_LOST, loss_cand_r)
  // a waiting item moves on as soon as the result register is free
  `CLED_ASSERT_NEXT(a_stage_moves, s1_valid_r && !out_valid_r, out_valid_r)

endmodule

FILE: hdl/cled_enable_deb.sv
// ----------------------------------------------------------------------------
// cled_enable_deb
// One enable channel: candidate, saturating confirm counter and stable level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cled_enable_deb (
  input  logic                         clk,
  input  logic                         rst_n,
  input  cled_pkg::enable_ctl_t        ctl,
  input  logic [cled_pkg::COUNT_W-1:0] confirm_cnt,
  output logic                         stable_nxt,
  output logic                         reached_nxt
);

  logic                         stable_r;
  logic                         cand_r;
  logic                         cand_nxt;
  logic [cled_pkg::COUNT_W-1:0] cnt_r;
  logic [cled_pkg::COUNT_W-1:0] cnt_nxt;

  always_comb begin
    stable_nxt = stable_r;
    cand_nxt   = cand_r;
    cnt_nxt    = cnt_r;
    if (ctl.init) begin
      stable_nxt = 1'b0;
      cand_nxt   = ctl.act;
      cnt_nxt    = '0;
    end else if (ctl.sample) begin
      if (ctl.act != cand_r) begin
        // new candidate restarts the count, no stable update this sample
        cand_nxt = ctl.act;
        cnt_nxt  = {{(cled_pkg::COUNT_W-1){1'b0}}, 1'b1};
      end else begin
        if (cnt_r < confirm_cnt) begin
          cnt_nxt = cnt_r + 1'b1;
        end
        if (cnt_nxt >= confirm_cnt) begin
          stable_nxt = cand_r;
        end
      end
    end
  end

  assign reached_nxt = (cnt_nxt >= confirm_cnt);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stable_r <= 1'b0;
      cand_r   <= 1'b0;
      cnt_r    <= '0;
    end else if (ctl.upd) begin
      stable_r <= stable_nxt;
      cand_r   <= cand_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule
